>>> rtl/anfsra_pkg.sv
// Shared constants, types and the monomial table function of the ANF
// shift-register automaton. No dependencies.
package anfsra_pkg;

	// Widths fixed by the item and register formats
	localparam int unsigned STATE_W        = 5;
	localparam int unsigned MAX_STATE_BITS = 5;
	localparam int unsigned MAX_VARS       = MAX_STATE_BITS + 1;
	localparam int unsigned COEFF_W        = 64;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned CFG_DATA_W     = 64;
	localparam int unsigned DEF_STATE_BITS = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd2;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [COEFF_W-1:0] feedback;
		logic [COEFF_W-1:0] out_coeffs;
		logic               start_load;
		logic [STATE_W-1:0] start_value;
	} cfg_t;

	// Variable set of monomial idx over var_count variables. Order: the constant,
	// then subsets by size, each size in lexicographic order of sorted indexes.
	// Within one size, lexicographic order equals descending order of the
	// bit-reversed mask, so sweep v downward and reverse it.
	function automatic logic [MAX_VARS-1:0] mono_mask(input int unsigned var_count,
			input int unsigned idx);
		int unsigned pos;
		int unsigned ones;
		logic [MAX_VARS-1:0] res;
		logic [MAX_VARS-1:0] m;
		pos = 1;
		res = '0;
		for (int r = 1; r <= MAX_VARS; r++) begin
			for (int v = (1 << MAX_VARS) - 1; v >= 0; v--) begin
				if (r <= var_count && v < (1 << var_count)) begin
					m = '0;
					for (int k = 0; k < MAX_VARS; k++) begin
						if (k < var_count) begin
							m[k] = v[var_count - 1 - k];
						end
					end
					ones = $countones(m);
					if (ones == r) begin
						if (pos == idx) begin
							res = m;
						end
						pos++;
					end
				end
			end
		end
		return res;
	endfunction

endpackage

>>> rtl/anfsra_if.sv
// Valid/ready channel interfaces of the ANF shift-register automaton.
// Depends on anfsra_pkg.

// Input item: one input symbol
interface anfsra_in_if;
	logic valid;
	logic ready;
	logic in_bit;
	modport source (output valid, output in_bit, input ready);
	modport sink (input valid, input in_bit, output ready);
endinterface

// Result item: output symbol and the state after the step
interface anfsra_out_if;
	logic                          valid;
	logic                          ready;
	logic                          out_bit;
	logic [anfsra_pkg::STATE_W-1:0] next_state;
	modport source (output valid, output out_bit, output next_state, input ready);
	modport sink (input valid, input out_bit, input next_state, output ready);
endinterface

// Configuration write channel
interface anfsra_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [anfsra_pkg::CFG_IDX_W-1:0]  index;
	logic [anfsra_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/anfsra_cfg_regs.sv
// Configuration register file: both coefficient vectors and the start state.
// Depends on anfsra_pkg and anfsra_cfg_if.
module anfsra_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	anfsra_cfg_if.sink         cfg,
	output anfsra_pkg::cfg_t   cfg_o
);
	import anfsra_pkg::*;

	logic               wr;
	logic [COEFF_W-1:0] feedback_q;
	logic [COEFF_W-1:0] out_coeffs_q;
	logic [STATE_W-1:0] start_q;

	// Always take a write; unknown indexes drop
	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;

	// Hold register contents between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_q   <= '0;
			out_coeffs_q <= '0;
			start_q      <= '0;
		end else if (wr) begin
			unique case (cfg.index)
				CFG_FEEDBACK: feedback_q   <= cfg.data;
				CFG_OUTPUT:   out_coeffs_q <= cfg.data;
				CFG_START:    start_q      <= cfg.data[STATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Pass the start value straight through so the state loads with the write
	always_comb begin
		cfg_o.feedback    = feedback_q;
		cfg_o.out_coeffs  = out_coeffs_q;
		cfg_o.start_load  = wr && (cfg.index == CFG_START);
		cfg_o.start_value = cfg_o.start_load ? cfg.data[STATE_W-1:0] : start_q;
	end

endmodule

>>> rtl/anfsra_anf_eval.sv
// Combinational evaluation of one algebraic normal form polynomial.
// Depends on anfsra_pkg for the monomial ordering.
module anfsra_anf_eval #(
	parameter int unsigned VARS = anfsra_pkg::DEF_STATE_BITS + 1
) (
	input  logic [(1 << VARS)-1:0] coeffs,
	input  logic [VARS-1:0]        vars,
	output logic                   value
);
	import anfsra_pkg::*;

	localparam int unsigned MONO_N = 1 << VARS;

	logic [MONO_N-1:0] terms;

	// Select each monomial whose variables are all set
	for (genvar i = 0; i < MONO_N; i++) begin : g_mono
		localparam logic [VARS-1:0] MASK = VARS'(mono_mask(VARS, i));
		assign terms[i] = coeffs[i] & ((vars & MASK) == MASK);
	end

	// Sum over GF(2)
	assign value = ^terms;

endmodule

>>> rtl/anf_shift_register_automaton_core.sv
// Top level of the ANF shift-register automaton: input register, two ANF
// evaluators, state register and result register. Depends on anfsra_pkg,
// anfsra_if, anfsra_cfg_regs and anfsra_anf_eval.
//
//   channel  dir  payload                  transaction
//   cfg      in   index[1:0], data[63:0]   valid & ready, ready always high
//   din      in   in_bit                   valid & ready
//   dout     out  out_bit, next_state[4:0] valid & ready
//
// One item per cycle sustained while dout is ready; an item's result passes
// from its din transaction through the input register and then the result
// register before it is valid on dout.
// The state register closes a loop through the feedback evaluator.
// Reset clears the configuration, the state and the valid flags, so the state
// starts at zero; a start_state write loads the state at once.
// A stalled dout holds its result; din keeps taking one more item into the
// input register, then drops ready until dout drains.
module anf_shift_register_automaton_core #(
	parameter int unsigned STATE_BITS = anfsra_pkg::DEF_STATE_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	anfsra_cfg_if.sink   cfg,
	anfsra_in_if.sink    din,
	anfsra_out_if.source dout
);
	import anfsra_pkg::*;

	localparam int unsigned VARS   = STATE_BITS + 1;
	localparam int unsigned MONO_N = 1 << VARS;

	cfg_t                  cfg_s;
	logic                  valid_s1;
	logic                  in_bit_s1;
	logic                  valid_s2;
	logic                  out_bit_s2;
	logic [STATE_W-1:0]    next_state_s2;
	logic [STATE_BITS-1:0] state_q;
	logic [STATE_BITS-1:0] nxt;
	logic [VARS-1:0]       vars;
	logic                  phi;
	logic                  psi;
	logic                  advance;

	anfsra_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_s)
	);

	// Step handshake: move s1 into the result register when it is free
	assign advance   = valid_s1 & (~valid_s2 | dout.ready);
	assign din.ready = ~valid_s1 | advance;

	// Evaluate both polynomials on the current state and input
	assign vars = {in_bit_s1, state_q};

	anfsra_anf_eval #(.VARS(VARS)) u_phi (
		.coeffs (cfg_s.feedback[MONO_N-1:0]),
		.vars   (vars),
		.value  (phi)
	);

	anfsra_anf_eval #(.VARS(VARS)) u_psi (
		.coeffs (cfg_s.out_coeffs[MONO_N-1:0]),
		.vars   (vars),
		.value  (psi)
	);

	// Shift feedback in at the top, drop s0
	always_comb begin
		nxt             = state_q >> 1;
		nxt[STATE_BITS-1] = phi;
	end

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (din.ready) begin
				valid_s1 <= din.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (dout.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			in_bit_s1 <= din.in_bit;
		end
		if (advance) begin
			out_bit_s2    <= psi;
			next_state_s2 <= STATE_W'(nxt);
		end
	end

	// Advance the automaton state, or restart it from the configured start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cfg_s.start_load) begin
			state_q <= cfg_s.start_value[STATE_BITS-1:0];
		end else if (advance) begin
			state_q <= nxt;
		end
	end

	assign dout.valid      = valid_s2;
	assign dout.out_bit    = out_bit_s2;
	assign dout.next_state = next_state_s2;

	// Reported state tracks the state register after each step
	a_step_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg_s.start_load |=> valid_s2 && next_state_s2 == STATE_W'(state_q))
		else $error("result state differs from state register");

	// A start write restarts the state from the written value
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_s.start_load |=> state_q == $past(cfg_s.start_value[STATE_BITS-1:0]))
		else $error("start state not loaded");

	// An accepted input lands in the input register
	a_in_capture: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> valid_s1 && in_bit_s1 == $past(din.in_bit))
		else $error("input transaction not captured");

	// A blocked input stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(in_bit_s1))
		else $error("stalled input item lost");

endmodule
